@@ hw/rtl/caf_pkg.sv @@
`default_nettype none
package caf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH    = 4;

  // command codes
  localparam logic [3:0] CMD_ADD = 4'd0;
  localparam logic [3:0] CMD_SUB = 4'd1;
  localparam logic [3:0] CMD_MUL = 4'd2;
  localparam logic [3:0] CMD_DIV = 4'd3;
  localparam logic [3:0] CMD_NEG = 4'd4;
  localparam logic [3:0] CMD_GT  = 4'd5;
  localparam logic [3:0] CMD_LT  = 4'd6;
  localparam logic [3:0] CMD_GE  = 4'd7;
  localparam logic [3:0] CMD_LE  = 4'd8;
  localparam logic [3:0] CMD_EQ  = 4'd9;
  localparam logic [3:0] CMD_NE  = 4'd10;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  // how the back end finishes a transaction
  typedef enum logic [1:0] {
    CLS_DONE,
    CLS_MUL,
    CLS_DIV
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic       neg;
    logic [1:0] status;
  } ctl_t;

endpackage
`default_nettype wire

@@ hw/rtl/caf_if.sv @@
`default_nettype none
interface caf_cmd_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic [3:0]          cmd;
  logic signed [W-1:0] left_operand;
  logic signed [W-1:0] right_operand;
  modport source (output valid, cmd, left_operand, right_operand, input ready);
  modport sink   (input valid, cmd, left_operand, right_operand, output ready);
endinterface

interface caf_res_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] value;
  logic [1:0]          status;
  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/caf_front.sv @@
`default_nettype none
module caf_front
  import caf_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  wire logic [3:0]   cmd,
  input  wire logic [W-1:0] left_operand,
  input  wire logic [W-1:0] right_operand,
  output ctl_t              ctl,
  output logic [W-1:0]      opa,
  output logic [W-1:0]      opb
);

  logic [W:0]   sum;
  logic [W:0]   diff;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic         lt;
  logic         gt;
  logic         a_min;
  logic         b_zero;
  logic         b_mone;

  // form sums at one extra bit so overflow shows in the top two bits
  assign sum    = {left_operand[W-1], left_operand} + {right_operand[W-1], right_operand};
  assign diff   = {left_operand[W-1], left_operand} - {right_operand[W-1], right_operand};
  assign mag_a  = left_operand[W-1] ? (~left_operand + W'(1)) : left_operand;
  assign mag_b  = right_operand[W-1] ? (~right_operand + W'(1)) : right_operand;
  assign lt     = $signed(left_operand) < $signed(right_operand);
  assign gt     = $signed(right_operand) < $signed(left_operand);
  assign a_min  = left_operand == {1'b1, {(W-1){1'b0}}};
  assign b_zero = right_operand == '0;
  assign b_mone = &right_operand;

  // classify: finish simple commands here, hand magnitudes on for mul and div
  always_comb begin
    ctl.cls    = CLS_DONE;
    ctl.neg    = left_operand[W-1] ^ right_operand[W-1];
    ctl.status = ST_OK;
    opa        = '0;
    opb        = mag_b;
    case (cmd)
      CMD_ADD: begin
        if (sum[W] != sum[W-1]) ctl.status = ST_OVF;
        else opa = sum[W-1:0];
      end
      CMD_SUB: begin
        if (diff[W] != diff[W-1]) ctl.status = ST_OVF;
        else opa = diff[W-1:0];
      end
      CMD_MUL: begin
        ctl.cls = CLS_MUL;
        opa     = mag_a;
      end
      CMD_DIV: begin
        if (b_zero) ctl.status = ST_DIVZ;
        else if (a_min && b_mone) ctl.status = ST_OVF;
        else begin
          ctl.cls = CLS_DIV;
          opa     = mag_a;
        end
      end
      CMD_NEG: begin
        if (a_min) ctl.status = ST_OVF;
        else opa = ~left_operand + W'(1);
      end
      CMD_GT:  opa = W'(gt);
      CMD_LT:  opa = W'(lt);
      CMD_GE:  opa = W'(!lt);
      CMD_LE:  opa = W'(!gt);
      CMD_EQ:  opa = W'(left_operand == right_operand);
      CMD_NE:  opa = W'(left_operand != right_operand);
      default: opa = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/caf_queue.sv @@
`default_nettype none
module caf_queue
  import caf_pkg::*;
#(
  parameter int W     = DATA_WIDTH_DEF,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire ctl_t         push_ctl,
  input  wire logic [W-1:0] push_a,
  input  wire logic [W-1:0] push_b,
  output logic              full,
  input  wire logic         pop,
  output logic              head_valid,
  output ctl_t              head_ctl,
  output logic [W-1:0]      head_a,
  output logic [W-1:0]      head_b
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ctl_t         mem_ctl [DEPTH];
  logic [W-1:0] mem_a   [DEPTH];
  logic [W-1:0] mem_b   [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full       = count == (PW+1)'(DEPTH);
  assign head_valid = count != '0;
  assign head_ctl   = mem_ctl[rd_ptr];
  assign head_a     = mem_a[rd_ptr];
  assign head_b     = mem_b[rd_ptr];

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_ctl[wr_ptr] <= push_ctl;
      mem_a[wr_ptr]   <= push_a;
      mem_b[wr_ptr]   <= push_b;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/caf_back.sv @@
`default_nettype none
module caf_back
  import caf_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         head_valid,
  input  wire ctl_t         head_ctl,
  input  wire logic [W-1:0] head_a,
  input  wire logic [W-1:0] head_b,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_value,
  output logic [1:0]        out_status
);

  logic            adv;
  logic            st_valid [W];
  ctl_t            st_ctl   [W];
  logic [2*W-1:0]  st_acc   [W];
  logic [2*W-1:0]  st_mcand [W];
  logic [W-1:0]    st_mplr  [W];
  logic [W-1:0]    st_rem   [W];
  logic [W-1:0]    st_dvd   [W];
  logic [W-1:0]    st_dvs   [W];

  // whole pipeline moves when the output register is free
  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic           in_valid;
    ctl_t           in_ctl;
    logic [2*W-1:0] in_acc;
    logic [2*W-1:0] in_mcand;
    logic [W-1:0]   in_mplr;
    logic [W-1:0]   in_rem;
    logic [W-1:0]   in_dvd;
    logic [W-1:0]   in_dvs;
    logic [W:0]     trial;
    logic           ge;

    if (k == 0) begin : g_head
      assign in_valid = head_valid;
      assign in_ctl   = head_ctl;
      assign in_acc   = (head_ctl.cls == CLS_DONE) ? {{W{1'b0}}, head_a} : '0;
      assign in_mcand = {{W{1'b0}}, head_a};
      assign in_mplr  = head_b;
      assign in_rem   = '0;
      assign in_dvd   = head_a;
      assign in_dvs   = head_b;
    end else begin : g_link
      assign in_valid = st_valid[k-1];
      assign in_ctl   = st_ctl[k-1];
      assign in_acc   = st_acc[k-1];
      assign in_mcand = st_mcand[k-1];
      assign in_mplr  = st_mplr[k-1];
      assign in_rem   = st_rem[k-1];
      assign in_dvd   = st_dvd[k-1];
      assign in_dvs   = st_dvs[k-1];
    end

    // one restoring-division bit
    assign trial = {in_rem, in_dvd[W-1]};
    assign ge    = trial >= {1'b0, in_dvs};

    // one shift-add multiply step and one divide step per stage
    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (adv) begin
        st_valid[k] <= in_valid;
      end
      if (adv) begin
        st_ctl[k]   <= in_ctl;
        st_acc[k]   <= (in_ctl.cls == CLS_MUL && in_mplr[0]) ? in_acc + in_mcand : in_acc;
        st_mcand[k] <= {in_mcand[2*W-2:0], 1'b0};
        st_mplr[k]  <= {1'b0, in_mplr[W-1:1]};
        st_rem[k]   <= ge ? W'(trial - {1'b0, in_dvs}) : trial[W-1:0];
        st_dvd[k]   <= {in_dvd[W-2:0], ge};
        st_dvs[k]   <= in_dvs;
      end
    end
  end

  ctl_t           fin_ctl;
  logic [2*W-1:0] prod;
  logic [W-1:0]   limit;
  logic [W-1:0]   fin_value;
  logic [1:0]     fin_status;

  assign fin_ctl = st_ctl[W-1];
  assign prod    = st_acc[W-1];
  assign limit   = fin_ctl.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

  // apply sign and range check
  always_comb begin
    fin_value  = '0;
    fin_status = fin_ctl.status;
    case (fin_ctl.cls)
      CLS_DONE: fin_value = prod[W-1:0];
      CLS_MUL: begin
        if (prod[2*W-1:W] != '0 || prod[W-1:0] > limit) fin_status = ST_OVF;
        else fin_value = fin_ctl.neg ? (~prod[W-1:0] + W'(1)) : prod[W-1:0];
      end
      CLS_DIV: begin
        fin_value = fin_ctl.neg ? (~st_dvd[W-1] + W'(1)) : st_dvd[W-1];
      end
      default: fin_value = '0;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= st_valid[W-1];
    end
    if (adv) begin
      out_value  <= fin_value;
      out_status <= fin_status;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/checked_integer_alu.sv @@
// Channel | Role | Payload
// req     | sink   | cmd[3:0], left_operand[W-1:0], right_operand[W-1:0]
// rsp     | source | value[W-1:0], status[1:0]
//
// One transaction per cycle is sustained while rsp is not stalled; results pass through
// the queue, the DATA_WIDTH-stage multiply/divide pipeline (one bit a stage) and an output register.
// Reset is synchronous and clears the queue and all stage valid bits.
// A stall on rsp freezes the pipeline; req keeps flowing until the
// QUEUE_DEPTH-entry queue between front and back is full.
`default_nettype none
module checked_integer_alu
  import caf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  caf_cmd_if.sink  req,
  caf_res_if.source rsp
);

  ctl_t                  f_ctl;
  logic [DATA_WIDTH-1:0] f_a;
  logic [DATA_WIDTH-1:0] f_b;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  ctl_t                  q_ctl;
  logic [DATA_WIDTH-1:0] q_a;
  logic [DATA_WIDTH-1:0] q_b;
  logic [DATA_WIDTH-1:0] r_value;

  assign req.ready = !q_full;

  caf_front #(.W(DATA_WIDTH)) u_front (
    .cmd           (req.cmd),
    .left_operand  (req.left_operand),
    .right_operand (req.right_operand),
    .ctl           (f_ctl),
    .opa           (f_a),
    .opb           (f_b)
  );

  caf_queue #(.W(DATA_WIDTH), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (req.valid && !q_full),
    .push_ctl   (f_ctl),
    .push_a     (f_a),
    .push_b     (f_b),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_ctl   (q_ctl),
    .head_a     (q_a),
    .head_b     (q_b)
  );

  caf_back #(.W(DATA_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head_ctl   (q_ctl),
    .head_a     (q_a),
    .head_b     (q_b),
    .pop        (q_pop),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_value  (r_value),
    .out_status (rsp.status)
  );

  assign rsp.value = r_value;

endmodule
`default_nettype wire

@@ hw/rtl/caf_checker.sv @@
`default_nettype none
module caf_checker
  import caf_pkg::*;
#(
  parameter int W = DATA_WIDTH_DEF
) (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         rsp_valid,
  input wire logic         rsp_ready,
  input wire logic [W-1:0] rsp_value,
  input wire logic [1:0]   rsp_status
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
    else $error("stalled result changed");

  // drop value on any error
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_value == '0)
    else $error("error result carries a value");

  // status stays within its codes
  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_OVF || rsp_status == ST_DIVZ)
    else $error("unknown status code");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result presented after reset");

endmodule

bind checked_integer_alu caf_checker #(.W(DATA_WIDTH)) u_caf_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.value),
  .rsp_status (rsp.status)
);
`default_nettype wire
